>>> hdl/pbr_pkg.sv
// ---------------------------------------------------------------------------
// pbr_pkg
// Shared types, constants and command/status bundles for the pulse beat and
// rate detector.
// ---------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

    // smoothing window and sample format
    localparam int AVG_WINDOW  = 7;
    localparam int SAMPLE_BITS = 12;
    localparam int IDX_BITS    = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int FILL_BITS   = $clog2(AVG_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + FILL_BITS;

    // timing and rate formats
    localparam int TIME_BITS   = 32;
    localparam int REFR_BITS   = 16;
    localparam int RATE_BITS   = 8;
    localparam int INST_BITS   = 16;
    localparam int AVG_BITS    = 24;
    localparam int Q_FRAC_BITS = 16;

    // shared serial divider
    localparam int DIV_BITS     = 28;
    localparam int DIVISOR_BITS = 32;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

    // divide by ten as multiply by ceil(2^31 / 10), exact for 28-bit blends
    localparam int PROD_BITS   = 2 * DIV_BITS;
    localparam int BLEND_SHIFT = 31;

    localparam logic [INST_BITS-1:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [AVG_BITS-1:0]  Q_HALF        = 24'h008000;
    localparam logic [DIV_BITS-1:0]  BLEND_RECIP   = 28'hCCCCCCD;
    localparam logic [DIV_BITS-1:0]  BLEND_ROUND   = 28'd5;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFRACTORY_MS  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_MIN       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_MAX       = 3'd4;

    localparam logic [SAMPLE_BITS-1:0] HIGH_THRESHOLD_RST = 12'd2200;
    localparam logic [SAMPLE_BITS-1:0] LOW_THRESHOLD_RST  = 12'd1800;
    localparam logic [REFR_BITS-1:0]   REFRACTORY_MS_RST  = 16'd320;
    localparam logic [RATE_BITS-1:0]   RATE_MIN_RST       = 8'd40;
    localparam logic [RATE_BITS-1:0]   RATE_MAX_RST       = 8'd180;

    // input and result words
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   time_ms;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smoothed;
        logic                   beat;
        logic                   rate_updated;
        logic [RATE_BITS-1:0]   rate_bpm;
        logic                   led;
    } out_word_t;

    // which division the shared divider runs
    typedef enum logic [1:0] {
        DIV_SM,
        DIV_RATE
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     ring_upd;
        logic     div_start;
        div_sel_t div_sel;
        logic     sm_latch;
        logic     detect;
        logic     inst_latch;
        logic     blend;
        logic     avg_mul;
        logic     avg_latch;
        logic     out_load;
    } pbr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic rate_go;
        logic in_range;
    } pbr_status_t;

endpackage : pbr_pkg

`default_nettype wire

>>> hdl/pulse_beat_rate_detector_unit.sv
// ---------------------------------------------------------------------------
// pulse_beat_rate_detector_unit
// Pulse sensor beat and rate detector: moving average, hysteresis beat
// detection with refractory time, and an averaged beats-per-minute rate.
// ---------------------------------------------------------------------------
// One word in gives one word out, and the unit works on one word at a time.
// Every word runs the ring update, the smoothing divide and the beat test; a
// beat after an earlier beat also runs the rate divide, and a rate within the
// limits also the average blend. The next word is taken in the cycle after
// the result register is loaded at the earliest. The divides run on one
// shared restoring divider that produces one quotient bit per cycle: 15 bits
// for the moving average and 16 for 60000 / interval; the rate blend is
// divided by ten with a reciprocal multiply. A finished result waits in an
// output register, so the next word is taken while the previous one is still
// unclaimed; a result that is still unclaimed when the next one is done holds
// the unit until it is taken. Configuration writes take effect at once and
// belong to idle time.
`default_nettype none

module pulse_beat_rate_detector_unit
    import pbr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire in_word_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output out_word_t                      out_data,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    pbr_cmd_t    cmd;
    pbr_status_t status;

    // sequencer
    pbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    pbr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_data)
    );

endmodule : pulse_beat_rate_detector_unit

`default_nettype wire

>>> hdl/pbr_div.sv
// ---------------------------------------------------------------------------
// pbr_div
// Restoring divider, one quotient bit per cycle. The dividend comes in left
// aligned and the unit runs as many steps as it has significant bits.
// ---------------------------------------------------------------------------
`default_nettype none

module pbr_div
    import pbr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIV_BITS-1:0]     dividend,
    input  wire logic [DIVISOR_BITS-1:0] divisor,
    input  wire logic [DIV_CNT_BITS-1:0] steps,
    output logic                         done,
    output logic [DIV_BITS-1:0]          quotient
);

    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0]     quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] dvs_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_BITS-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        quo_next = {quo_reg[DIV_BITS-2:0], fits};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : pbr_div

`default_nettype wire

>>> hdl/pbr_datapath.sv
// ---------------------------------------------------------------------------
// pbr_datapath
// Smoothing ring, beat detection state, rate averaging and the result
// register, driven step by step by the controller.
// ---------------------------------------------------------------------------
`default_nettype none

module pbr_datapath
    import pbr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire in_word_t                  in_word,
    input  wire pbr_cmd_t                  cmd,
    output pbr_status_t                    status,
    output out_word_t                      out_word
);

    localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(AVG_WINDOW);
    localparam logic [IDX_BITS-1:0]  IDX_LAST  = IDX_BITS'(AVG_WINDOW - 1);

    // configuration registers
    logic [SAMPLE_BITS-1:0] high_thr_reg;
    logic [SAMPLE_BITS-1:0] low_thr_reg;
    logic [REFR_BITS-1:0]   refr_reg;
    logic [RATE_BITS-1:0]   rate_min_reg;
    logic [RATE_BITS-1:0]   rate_max_reg;

    // running state
    logic [SAMPLE_BITS-1:0] ring_reg [AVG_WINDOW];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic                   above_reg;
    logic [TIME_BITS-1:0]   last_beat_reg;
    logic [AVG_BITS-1:0]    avg_reg;
    logic [RATE_BITS-1:0]   pub_reg;
    logic                   led_reg;

    // per-word working registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_BITS-1:0]   time_reg;
    logic [SAMPLE_BITS-1:0] sm_reg;
    logic                   beat_reg;
    logic                   upd_reg;
    logic [TIME_BITS-1:0]   ibi_reg;
    logic [INST_BITS-1:0]   inst_reg;
    logic [DIV_BITS-1:0]    blend_reg;
    logic [AVG_BITS-1:0]    quo10_reg;
    out_word_t              out_reg;

    // combinational terms
    logic [SAMPLE_BITS-1:0]  old_sample;
    logic [SUM_BITS-1:0]     sum_next;
    logic [IDX_BITS-1:0]     idx_next;
    logic [TIME_BITS-1:0]    ibi;
    logic                    beat_ok;
    logic [AVG_BITS-1:0]     target;
    logic [AVG_BITS-1:0]     base;
    logic [DIV_BITS-1:0]     blend_next;
    logic [PROD_BITS-1:0]    blend_prod;
    logic [AVG_BITS:0]       round_sum;
    logic [DIV_BITS-1:0]     div_dividend;
    logic [DIVISOR_BITS-1:0] div_divisor;
    logic [DIV_CNT_BITS-1:0] div_steps;
    logic                    div_done;
    logic [DIV_BITS-1:0]     div_quo;

    // ring update; entries not yet filled count as zero
    always_comb
    begin
        old_sample = (fill_reg == FILL_FULL) ? ring_reg[idx_reg] : '0;
        sum_next   = sum_reg - SUM_BITS'(old_sample) + SUM_BITS'(sample_reg);
        idx_next   = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    end

    // beat test; an interval above the refractory time is never zero
    always_comb
    begin
        ibi     = time_reg - last_beat_reg;
        beat_ok = !above_reg && (sm_reg >= high_thr_reg) &&
                  (ibi > TIME_BITS'(refr_reg));
    end

    // rate average blend, seeded from the first accepted rate
    always_comb
    begin
        target     = {inst_reg[RATE_BITS-1:0], Q_FRAC_BITS'(0)};
        base       = (avg_reg == '0) ? target : avg_reg;
        blend_next = ({1'b0, base, 3'b000} - DIV_BITS'(base))
                   + {3'b000, target, 1'b0} + DIV_BITS'(target) + BLEND_ROUND;
        round_sum  = {1'b0, quo10_reg} + {1'b0, Q_HALF};
    end

    // blend divided by ten through the reciprocal
    assign blend_prod = PROD_BITS'(blend_reg) * PROD_BITS'(BLEND_RECIP);

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SM:
            begin
                div_dividend = {sum_reg, (DIV_BITS - SUM_BITS)'(0)};
                div_divisor  = DIVISOR_BITS'(fill_reg);
                div_steps    = DIV_CNT_BITS'(SUM_BITS);
            end
            DIV_RATE:
            begin
                div_dividend = {MS_PER_MINUTE, (DIV_BITS - INST_BITS)'(0)};
                div_divisor  = ibi_reg;
                div_steps    = DIV_CNT_BITS'(INST_BITS);
            end
            default:
            begin
                div_dividend = {sum_reg, (DIV_BITS - SUM_BITS)'(0)};
                div_divisor  = DIVISOR_BITS'(fill_reg);
                div_steps    = DIV_CNT_BITS'(SUM_BITS);
            end
        endcase
    end

    pbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quo)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THRESHOLD_RST;
            low_thr_reg  <= LOW_THRESHOLD_RST;
            refr_reg     <= REFRACTORY_MS_RST;
            rate_min_reg <= RATE_MIN_RST;
            rate_max_reg <= RATE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_REFRACTORY_MS:  refr_reg     <= cfg_data[REFR_BITS-1:0];
                REG_RATE_MIN:       rate_min_reg <= cfg_data[RATE_BITS-1:0];
                REG_RATE_MAX:       rate_max_reg <= cfg_data[RATE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            above_reg     <= 1'b0;
            last_beat_reg <= '0;
            avg_reg       <= '0;
            pub_reg       <= '0;
            led_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.ring_upd)
            begin
                sum_reg <= sum_next;
                idx_reg <= idx_next;
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.detect)
            begin
                if (beat_ok)
                begin
                    above_reg     <= 1'b1;
                    last_beat_reg <= time_reg;
                    led_reg       <= ~led_reg;
                end
                else if (above_reg && (sm_reg <= low_thr_reg))
                begin
                    above_reg <= 1'b0;
                end
            end
            if (cmd.avg_latch)
            begin
                avg_reg <= quo10_reg;
                pub_reg <= round_sum[AVG_BITS-1:Q_FRAC_BITS];
            end
        end
    end

    // sample ring, valid only up to the fill count
    always_ff @(posedge clk)
    begin
        if (cmd.ring_upd)
        begin
            ring_reg[idx_reg] <= sample_reg;
        end
    end

    // per-word working values
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= in_word.sample;
            time_reg   <= in_word.time_ms;
            beat_reg   <= 1'b0;
            upd_reg    <= 1'b0;
        end
        if (cmd.sm_latch)
        begin
            sm_reg <= div_quo[SAMPLE_BITS-1:0];
        end
        if (cmd.detect)
        begin
            beat_reg <= beat_ok;
            ibi_reg  <= ibi;
        end
        if (cmd.inst_latch)
        begin
            inst_reg <= div_quo[INST_BITS-1:0];
        end
        if (cmd.blend)
        begin
            blend_reg <= blend_next;
        end
        if (cmd.avg_mul)
        begin
            quo10_reg <= blend_prod[BLEND_SHIFT +: AVG_BITS];
        end
        if (cmd.avg_latch)
        begin
            upd_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.smoothed     <= sm_reg;
            out_reg.beat         <= beat_reg;
            out_reg.rate_updated <= upd_reg;
            out_reg.rate_bpm     <= pub_reg;
            out_reg.led          <= led_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.div_done = div_done;
        status.rate_go  = beat_ok && (last_beat_reg != '0);
        status.in_range = (inst_reg >= INST_BITS'(rate_min_reg)) &&
                          (inst_reg <= INST_BITS'(rate_max_reg));
    end

    assign out_word = out_reg;

endmodule : pbr_datapath

`default_nettype wire

>>> hdl/pbr_ctrl.sv
// ---------------------------------------------------------------------------
// pbr_ctrl
// Sequencer for one word: ring update, smoothing divide, beat test, rate
// divide on a later beat, blend if in range, hand-off to the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module pbr_ctrl
    import pbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire pbr_status_t status,
    output pbr_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RING,
        S_SM_START,
        S_SM_WAIT,
        S_DETECT,
        S_RATE_START,
        S_RATE_WAIT,
        S_RANGE,
        S_AVG_MUL,
        S_AVG_LATCH,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_sel    = DIV_SM;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RING;
                end
            end
            S_RING:
            begin
                cmd.ring_upd = 1'b1;
                state_next   = S_SM_START;
            end
            S_SM_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SM;
                state_next    = S_SM_WAIT;
            end
            S_SM_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sm_latch = 1'b1;
                    state_next   = S_DETECT;
                end
            end
            S_DETECT:
            begin
                cmd.detect = 1'b1;
                state_next = status.rate_go ? S_RATE_START : S_FINISH;
            end
            S_RATE_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_RATE;
                state_next    = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.inst_latch = 1'b1;
                    state_next     = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (status.in_range)
                begin
                    cmd.blend  = 1'b1;
                    state_next = S_AVG_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_AVG_MUL:
            begin
                cmd.avg_mul = 1'b1;
                state_next  = S_AVG_LATCH;
            end
            S_AVG_LATCH:
            begin
                cmd.avg_latch = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule : pbr_ctrl

`default_nettype wire

>>> hdl/pbr_checker.sv
// ---------------------------------------------------------------------------
// pbr_checker
// Port-level checks on the detector: result word hold, one word in flight,
// rate updates only on beats, and no result word straight out of reset.
// ---------------------------------------------------------------------------
`default_nettype none

module pbr_checker
    import pbr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_word_t out_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // one word is worked on at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while a word is in progress");

    // a rate is published only on a beat
    a_rate_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.rate_updated || out_data.beat))
        else $error("rate update without a beat");

    // no result word straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word valid after reset");

endmodule : pbr_checker

bind pulse_beat_rate_detector_unit pbr_checker u_pbr_checker (.*);

`default_nettype wire

>>> sim/tb_pulse_beat_rate_detector_unit.sv
// ---------------------------------------------------------------------------
// tb_pulse_beat_rate_detector_unit
// Self-checking bench for the pulse beat and rate detector. A behavioral
// tracker predicts one result word per accepted sample word. Directed pulses
// cover field extremes, first beat, beat at tick zero, timestamp wrap, rate
// limits and register masking. Random pulse trains with noise and random
// register settings follow, under three sender and receiver idle patterns.
// ---------------------------------------------------------------------------

module tb_pulse_beat_rate_detector_unit;
    import pbr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int SETTLE_CYCLES = 200;

    // blend weights of the exponential rate average
    localparam logic [31:0] BLEND_OLD_WEIGHT = 32'd7;
    localparam logic [31:0] BLEND_NEW_WEIGHT = 32'd3;
    localparam logic [31:0] BLEND_DIVISOR    = 32'd10;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_word_t                  in_data;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_word_t                 out_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // register copies held by the tracker
    logic [SAMPLE_BITS-1:0] thr_high;
    logic [SAMPLE_BITS-1:0] thr_low;
    logic [REFR_BITS-1:0]   refractory_lim;
    logic [RATE_BITS-1:0]   rate_floor;
    logic [RATE_BITS-1:0]   rate_ceil;

    // tracker state
    logic [SAMPLE_BITS-1:0] ring_samples [AVG_WINDOW];
    int unsigned            ring_total;
    int unsigned            ring_slot;
    int unsigned            ring_count;
    logic                   beat_latched;
    logic [TIME_BITS-1:0]   last_beat_ms;
    logic [AVG_BITS-1:0]    rate_avg_q16;
    logic [RATE_BITS-1:0]   shown_rate;
    logic                   led_state;

    out_word_t            pending_words [$];
    logic [TIME_BITS-1:0] pulse_ms;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    pulse_beat_rate_detector_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_data.smoothed !== want.smoothed)
                begin
                    $error("smoothed: expected %0d, actual %0d", want.smoothed,
                           out_data.smoothed);
                    fail_count++;
                end
                if (out_data.beat !== want.beat)
                begin
                    $error("beat: expected %0d, actual %0d", want.beat, out_data.beat);
                    fail_count++;
                end
                if (out_data.rate_updated !== want.rate_updated)
                begin
                    $error("rate_updated: expected %0d, actual %0d", want.rate_updated,
                           out_data.rate_updated);
                    fail_count++;
                end
                if (out_data.rate_bpm !== want.rate_bpm)
                begin
                    $error("rate_bpm: expected %0d, actual %0d", want.rate_bpm,
                           out_data.rate_bpm);
                    fail_count++;
                end
                if (out_data.led !== want.led)
                begin
                    $error("led: expected %0d, actual %0d", want.led, out_data.led);
                    fail_count++;
                end
            end
        end
    end

    // tracker back to its reset state
    task automatic reset_tracker();
        thr_high       = HIGH_THRESHOLD_RST;
        thr_low        = LOW_THRESHOLD_RST;
        refractory_lim = REFRACTORY_MS_RST;
        rate_floor     = RATE_MIN_RST;
        rate_ceil      = RATE_MAX_RST;
        foreach (ring_samples[i])
            ring_samples[i] = '0;
        ring_total   = 0;
        ring_slot    = 0;
        ring_count   = 0;
        beat_latched = 1'b0;
        last_beat_ms = '0;
        rate_avg_q16 = '0;
        shown_rate   = '0;
        led_state    = 1'b0;
    endtask

    // register write as seen by the tracker, masked to width
    task automatic track_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_HIGH_THRESHOLD: thr_high       = data[SAMPLE_BITS-1:0];
            REG_LOW_THRESHOLD:  thr_low        = data[SAMPLE_BITS-1:0];
            REG_REFRACTORY_MS:  refractory_lim = data[REFR_BITS-1:0];
            REG_RATE_MIN:       rate_floor     = data[RATE_BITS-1:0];
            REG_RATE_MAX:       rate_ceil      = data[RATE_BITS-1:0];
            default: ;
        endcase
    endtask

    // smoothing, beat detection and rate average for one accepted word
    task automatic track_beat_word(input in_word_t w);
        out_word_t   want;
        logic [31:0] sm;
        logic [31:0] ibi;
        logic [31:0] inst;
        logic [31:0] target;
        logic [31:0] blend;
        want = '0;
        ring_total = ring_total - ring_samples[ring_slot] + w.sample;
        ring_samples[ring_slot] = w.sample;
        ring_slot = (ring_slot + 1 >= AVG_WINDOW) ? 0 : ring_slot + 1;
        if (ring_count < AVG_WINDOW)
            ring_count++;
        sm  = ring_total / ring_count;
        ibi = w.time_ms - last_beat_ms;
        if (!beat_latched && sm >= thr_high && ibi > refractory_lim)
        begin
            beat_latched = 1'b1;
            want.beat = 1'b1;
            // a zero last-beat time means no earlier beat
            if (last_beat_ms != '0 && ibi != '0)
            begin
                inst = MS_PER_MINUTE / ibi;
                if (inst >= rate_floor && inst <= rate_ceil)
                begin
                    target = inst << Q_FRAC_BITS;
                    if (rate_avg_q16 == '0)
                        rate_avg_q16 = target[AVG_BITS-1:0];
                    blend = (BLEND_OLD_WEIGHT * rate_avg_q16 + BLEND_NEW_WEIGHT * target
                             + BLEND_ROUND) / BLEND_DIVISOR;
                    rate_avg_q16 = blend[AVG_BITS-1:0];
                    blend = rate_avg_q16 + Q_HALF;
                    shown_rate = blend[Q_FRAC_BITS +: RATE_BITS];
                    want.rate_updated = 1'b1;
                end
            end
            last_beat_ms = w.time_ms;
            led_state = ~led_state;
        end
        else if (beat_latched && sm <= thr_low)
        begin
            beat_latched = 1'b0;
        end
        want.smoothed = sm[SAMPLE_BITS-1:0];
        want.rate_bpm = shown_rate;
        want.led      = led_state;
        pending_words.push_back(want);
    endtask

    // send one sample word, with a random gap before it
    task automatic send_word(input logic [SAMPLE_BITS-1:0] level,
                             input logic [TIME_BITS-1:0] stamp);
        in_word_t w;
        w.sample  = level;
        w.time_ms = stamp;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        track_beat_word(w);
        pulse_ms = stamp;
    endtask

    // drop valid and wait for every predicted word to come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // one register write; the caller lowers the enable
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        track_reg_write(idx, data);
    endtask

    // full register set while idle, plus junk writes to unused indexes
    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] hi,
                                input logic [CFG_DATA_BITS-1:0] lo,
                                input logic [CFG_DATA_BITS-1:0] refr,
                                input logic [CFG_DATA_BITS-1:0] rmin,
                                input logic [CFG_DATA_BITS-1:0] rmax);
        wait_idle();
        write_reg(REG_HIGH_THRESHOLD, hi);
        write_reg(REG_LOW_THRESHOLD, lo);
        write_reg(REG_REFRACTORY_MS, refr);
        write_reg(REG_RATE_MIN, rmin);
        write_reg(REG_RATE_MAX, rmax);
        for (int i = int'(REG_RATE_MAX) + 1; i < (1 << CFG_INDEX_BITS); i++)
            write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // with thresholds inverted every armed word beats and the next one rearms
    task automatic beat_and_rearm(input logic [TIME_BITS-1:0] stamp);
        send_word({SAMPLE_BITS{1'b1}}, stamp);
        send_word('0, stamp);
    endtask

    // field extremes under reset settings
    task automatic test_field_extremes();
        send_word('0, '0);
        send_word({SAMPLE_BITS{1'b1}}, {TIME_BITS{1'b1}});
        send_word({SAMPLE_BITS{1'b1}}, 32'h8000_0000);
        send_word('0, 32'h0000_0001);
    endtask

    // first beat, beat at tick zero, timestamp wrap, rate above limit
    task automatic test_special_cases();
        // upper bits of each write must be dropped: high 0, low 4095, rates 40..180
        program_regs(16'hF000, 16'hFFFF, 16'h0000, 16'h1228, 16'hFFB4);
        beat_and_rearm(32'd100);
        beat_and_rearm(32'd600);
        beat_and_rearm(32'd0);
        beat_and_rearm(32'd1000);
        beat_and_rearm(32'hFFFF_FE00);
        beat_and_rearm(32'h0000_0100);
        beat_and_rearm(32'h0000_0100 + 32'd200);
    endtask

    // zero rate accepted, limits crossed, refractory at its extreme
    task automatic test_rate_limits();
        program_regs(16'd0, 16'd4095, 16'd0, 16'd0, 16'd255);
        beat_and_rearm(pulse_ms + 32'd70000);
        beat_and_rearm(pulse_ms + 32'd236);
        program_regs(16'd0, 16'd4095, 16'd0, 16'd255, 16'd0);
        beat_and_rearm(pulse_ms + 32'd600);
        program_regs(16'd0, 16'd4095, 16'd65535, 16'd40, 16'd180);
        send_word(12'd2048, pulse_ms + 32'd65535);
        beat_and_rearm(pulse_ms + 32'd1);
    endtask

    // random register set: reset values, extremes, full range or typical
    task automatic pick_settings();
        int unsigned hi;
        case ($urandom_range(5))
            0: program_regs(CFG_DATA_BITS'(HIGH_THRESHOLD_RST),
                            CFG_DATA_BITS'(LOW_THRESHOLD_RST),
                            CFG_DATA_BITS'(REFRACTORY_MS_RST),
                            CFG_DATA_BITS'(RATE_MIN_RST), CFG_DATA_BITS'(RATE_MAX_RST));
            1: program_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
            2: program_regs(CFG_DATA_BITS'($urandom()), CFG_DATA_BITS'($urandom()),
                            CFG_DATA_BITS'($urandom()), CFG_DATA_BITS'($urandom()),
                            CFG_DATA_BITS'($urandom()));
            default:
            begin
                hi = $urandom_range(3500, 1200);
                program_regs(CFG_DATA_BITS'(hi), CFG_DATA_BITS'($urandom_range(hi, 200)),
                             CFG_DATA_BITS'($urandom_range(600, 0)),
                             CFG_DATA_BITS'($urandom_range(80, 0)),
                             CFG_DATA_BITS'($urandom_range(255, 100)));
            end
        endcase
    endtask

    // pulse periods around the current thresholds, with noise bursts
    task automatic run_pulse_block(input int n_items);
        int left;
        int lo_len;
        int hi_len;
        int step;
        int burst;
        left = n_items;
        if ($urandom_range(3) == 0)
            pulse_ms = 32'hFFFF_F000 + $urandom_range(4095);
        else
            pulse_ms = $urandom();
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: random level, time near or far
                burst = $urandom_range(4, 1);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    send_word(SAMPLE_BITS'($urandom_range(4095)),
                              $urandom_range(1) ? $urandom() : pulse_ms + $urandom_range(50));
                    left--;
                end
            end
            else
            begin
                case ($urandom_range(9))
                    0:       step = $urandom_range(5, 1);
                    1:       step = $urandom_range(6000, 2000);
                    default: step = $urandom_range(120, 10);
                endcase
                lo_len = $urandom_range(12, 2);
                hi_len = $urandom_range(12, 2);
                for (int k = 0; k < lo_len + hi_len && left > 0; k++)
                begin
                    send_word(SAMPLE_BITS'((k < lo_len) ? $urandom_range(thr_low, 0)
                                                        : $urandom_range(4095, thr_high)),
                              pulse_ms + step + $urandom_range(step / 4));
                    left--;
                end
            end
        end
    endtask

    // random pulse trains under one idle pattern, settings changed per block
    task automatic test_random_pulse_trains(input int send_pct, input int recv_pct,
                                            input int n_items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < 5; b++)
        begin
            pick_settings();
            run_pulse_block(n_items / 5);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pulse_ms  = '0;
        send_idle_pct = 36;
        recv_idle_pct = 72;
        reset_tracker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_special_cases();
        test_rate_limits();
        test_random_pulse_trains(36, 72, 550);
        test_random_pulse_trains(72, 36, 550);
        test_random_pulse_trains(0, 0, 550);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> pulse_beat_rate_detector_unit.f
hdl/pbr_pkg.sv
hdl/pbr_div.sv
hdl/pbr_datapath.sv
hdl/pbr_ctrl.sv
hdl/pulse_beat_rate_detector_unit.sv
hdl/pbr_checker.sv
sim/tb_pulse_beat_rate_detector_unit.sv
